### hw/rtl/sipf_pkg.sv
// Shared types, constants and the CRC-16 byte update for the servo packet framer.
// Used by every module of the framer; depends on nothing.
package sipf_pkg;

    // Input item as it arrives on the request channel.
    typedef struct packed {
        logic       op;
        logic [7:0] target_id;
        logic [7:0] instruction;
        logic [7:0] param_count;
        logic [7:0] data_byte;
    } in_item_t;

    // One byte of the framed packet.
    typedef struct packed {
        logic [7:0] out_byte;
        logic       last;
        logic       error;
    } out_item_t;

    localparam logic OP_START = 1'b0;
    localparam logic OP_PARAM = 1'b1;

    localparam logic [7:0] MAX_PARAMS = 8'd252;
    localparam logic [7:0] LEN_EXTRA  = 8'd3;

    localparam logic [7:0]  HDR_SYNC    = 8'hFF;
    localparam logic [7:0]  HDR_MARK    = 8'hFD;
    localparam logic [7:0]  HDR_ZERO    = 8'h00;
    localparam logic [15:0] CRC_POLY    = 16'h8005;
    localparam logic [15:0] CRC_INIT    = 16'h0000;

    // Classified command held in the queue between the two halves.
    localparam int unsigned KIND_W = 2;
    localparam logic [KIND_W-1:0] KIND_START = 2'd0;
    localparam logic [KIND_W-1:0] KIND_PARAM = 2'd1;
    localparam logic [KIND_W-1:0] KIND_STRAY = 2'd2;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [7:0]        first;    // target id on a start, data on a parameter
        logic [7:0]        instr;
        logic [7:0]        len_lo;
        logic              tail;     // the CRC follows this command
    } q_entry_t;

    localparam int unsigned QUEUE_DEPTH = 4;
    localparam int unsigned QUEUE_AW    = $clog2(QUEUE_DEPTH);

    localparam int unsigned STEP_W = 4;

    function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] b);
        logic [15:0] c;
        c = crc_in ^ {b, 8'h00};
        for (int k = 0; k < 8; k++) begin
            if (c[15])
            begin
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            end
            else
            begin
                c = {c[14:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

### hw/rtl/sipf_front.sv
// Front half of the servo packet framer: accepts requests and classifies them.
// Tracks the open packet and its remaining parameter count; uses sipf_pkg.
module sipf_front (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cmd_valid,
    input  sipf_pkg::in_item_t cmd,
    output logic               cmd_stall,
    input  logic               q_full,
    output logic               q_push,
    output sipf_pkg::q_entry_t q_entry
);
    import sipf_pkg::*;

    logic [7:0] left_reg, left_next;
    logic       open_reg, open_next;
    logic [7:0] count_sat;

    assign cmd_stall = q_full;
    assign q_push    = cmd_valid && !q_full;
    assign count_sat = (cmd.param_count > MAX_PARAMS) ? MAX_PARAMS : cmd.param_count;

    always_comb
    begin
        left_next      = left_reg;
        open_next      = open_reg;
        q_entry.first  = cmd.data_byte;
        q_entry.instr  = cmd.instruction;
        q_entry.len_lo = count_sat + LEN_EXTRA;
        q_entry.tail   = 1'b0;
        q_entry.kind   = KIND_STRAY;
        if (cmd.op == OP_START)
        begin
            q_entry.kind  = KIND_START;
            q_entry.first = cmd.target_id;
            q_entry.tail  = (count_sat == 8'd0);
            left_next     = count_sat;
            open_next     = (count_sat != 8'd0);
        end
        else if (open_reg && left_reg != 8'd0)
        begin
            q_entry.kind = KIND_PARAM;
            q_entry.tail = (left_reg == 8'd1);
            left_next    = left_reg - 8'd1;
            open_next    = (left_reg != 8'd1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            left_reg <= 8'd0;
            open_reg <= 1'b0;
        end
        else if (q_push)
        begin
            left_reg <= left_next;
            open_reg <= open_next;
        end
    end

endmodule

### hw/rtl/sipf_queue.sv
// Short command queue between the front and back halves of the framer.
// Register-based FIFO sized by sipf_pkg::QUEUE_DEPTH.
module sipf_queue (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  sipf_pkg::q_entry_t push_entry,
    input  logic               pop,
    output sipf_pkg::q_entry_t head,
    output logic               full,
    output logic               empty
);
    import sipf_pkg::*;

    q_entry_t              slots_reg [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0]   wr_reg, wr_next;
    logic [QUEUE_AW-1:0]   rd_reg, rd_next;
    logic [QUEUE_AW:0]     count_reg, count_next;

    assign full  = (count_reg == (QUEUE_AW + 1)'(QUEUE_DEPTH));
    assign empty = (count_reg == '0);
    assign head  = slots_reg[rd_reg];

    always_comb
    begin
        wr_next    = push ? wr_reg + 1'b1 : wr_reg;
        rd_next    = pop ? rd_reg + 1'b1 : rd_reg;
        count_next = count_reg + (QUEUE_AW + 1)'(push) - (QUEUE_AW + 1)'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slots_reg[wr_reg] <= push_entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg    <= '0;
            rd_reg    <= '0;
            count_reg <= '0;
        end
        else
        begin
            wr_reg    <= wr_next;
            rd_reg    <= rd_next;
            count_reg <= count_next;
        end
    end

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n) full |-> !push)
        else $error("queue written while full");
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n) empty |-> !pop)
        else $error("queue read while empty");
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= (QUEUE_AW + 1)'(QUEUE_DEPTH))
        else $error("queue count out of range");
`endif

endmodule

### hw/rtl/sipf_back.sv
// Back half of the servo packet framer: turns queued commands into packet bytes.
// Emits a byte per cycle unless stalled or idle; runs the CRC-16; uses sipf_pkg.
module sipf_back (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                q_empty,
    input  sipf_pkg::q_entry_t  q_head,
    output logic                q_pop,
    output logic                pkt_valid,
    input  logic                pkt_stall,
    output sipf_pkg::out_item_t pkt
);
    import sipf_pkg::*;

    localparam logic [STEP_W-1:0] STEP_HDR_LAST = 4'd7;
    localparam logic [STEP_W-1:0] STEP_HDR_CRC  = 4'd9;

    logic [STEP_W-1:0] step_reg, step_next;
    logic [15:0]       crc_reg, crc_next, crc_base;
    logic              valid_reg, valid_next;
    out_item_t         pkt_reg;

    logic       fire;
    logic       done;
    logic       is_data;
    out_item_t  cur;

    assign fire      = !q_empty && (!valid_reg || !pkt_stall);
    assign q_pop     = fire && done;
    assign pkt_valid = valid_reg;
    assign pkt       = pkt_reg;

    // A new packet always restarts the CRC from its first header byte.
    assign crc_base = (q_head.kind == KIND_START && step_reg == '0) ? CRC_INIT : crc_reg;

    always_comb
    begin
        cur.out_byte = HDR_ZERO;
        cur.last     = 1'b0;
        cur.error    = 1'b0;
        is_data      = 1'b1;
        done         = 1'b0;
        unique case (q_head.kind)
            KIND_START:
            begin
                unique case (step_reg)
                    4'd0, 4'd1: cur.out_byte = HDR_SYNC;
                    4'd2:       cur.out_byte = HDR_MARK;
                    4'd3, 4'd6: cur.out_byte = HDR_ZERO;
                    4'd4:       cur.out_byte = q_head.first;
                    4'd5:       cur.out_byte = q_head.len_lo;
                    4'd7:       cur.out_byte = q_head.instr;
                    4'd8:
                    begin
                        cur.out_byte = crc_reg[7:0];
                        is_data      = 1'b0;
                    end
                    default:
                    begin
                        cur.out_byte = crc_reg[15:8];
                        cur.last     = 1'b1;
                        is_data      = 1'b0;
                    end
                endcase
                done = q_head.tail ? (step_reg == STEP_HDR_CRC) : (step_reg == STEP_HDR_LAST);
            end
            KIND_PARAM:
            begin
                unique case (step_reg)
                    4'd0:    cur.out_byte = q_head.first;
                    4'd1:
                    begin
                        cur.out_byte = crc_reg[7:0];
                        is_data      = 1'b0;
                    end
                    default:
                    begin
                        cur.out_byte = crc_reg[15:8];
                        cur.last     = 1'b1;
                        is_data      = 1'b0;
                    end
                endcase
                done = q_head.tail ? (step_reg == 4'd2) : (step_reg == 4'd0);
            end
            default:
            begin
                // Parameter byte with no packet open.
                cur.last  = 1'b1;
                cur.error = 1'b1;
                is_data   = 1'b0;
                done      = 1'b1;
            end
        endcase
    end

    always_comb
    begin
        step_next  = step_reg;
        crc_next   = crc_reg;
        valid_next = valid_reg && pkt_stall;
        if (fire)
        begin
            valid_next = 1'b1;
            step_next  = done ? '0 : step_reg + 1'b1;
            if (is_data)
            begin
                crc_next = crc_byte(crc_base, cur.out_byte);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            pkt_reg <= cur;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg  <= '0;
            crc_reg   <= CRC_INIT;
            valid_reg <= 1'b0;
        end
        else
        begin
            step_reg  <= step_next;
            crc_reg   <= crc_next;
            valid_reg <= valid_next;
        end
    end

`ifndef SYNTHESIS
    a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
        step_reg <= STEP_HDR_CRC)
        else $error("byte counter out of range");
    a_step_has_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        step_reg != '0 |-> !q_empty)
        else $error("command left the queue in the middle of a packet");
    a_error_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg && pkt_reg.error |-> pkt_reg.last)
        else $error("error result not marked last");
`endif

endmodule

### hw/rtl/servo_instruction_packet_framer_unit.sv
// Servo-bus instruction packet framer, top level: front classifier, queue, byte emitter.
// Depends on sipf_pkg, sipf_front, sipf_queue and sipf_back.
//
// A start request produces the header FF FF FD 00, id, length (count + 3, count capped at
// 252), 00 and the instruction; each parameter request produces its byte, and the one that
// completes the packet is followed by the CRC-16 (poly 0x8005, init 0), low byte first, with
// last on the high byte. A start with a zero count emits all ten bytes. A parameter with no
// open packet gives one byte 00 flagged last and error; a start while a packet is open
// abandons it. Requests are taken one per cycle while the four-entry queue has room; the
// back end emits one byte per cycle while the queue holds a command and pkt_stall is low; a
// start yields 8 or 10 bytes and a parameter 1 or 3. A taken request is written into the
// queue first; the back end then registers its first byte with valid in the output register.
module servo_instruction_packet_framer_unit (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cmd_valid,
    input  sipf_pkg::in_item_t  cmd,
    output logic                cmd_stall,
    output logic                pkt_valid,
    input  logic                pkt_stall,
    output sipf_pkg::out_item_t pkt
);
    import sipf_pkg::*;

    logic     q_push;
    logic     q_pop;
    logic     q_full;
    logic     q_empty;
    q_entry_t q_in;
    q_entry_t q_head;

    sipf_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_stall (cmd_stall),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_entry   (q_in)
    );

    sipf_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_entry (q_in),
        .pop        (q_pop),
        .head       (q_head),
        .full       (q_full),
        .empty      (q_empty)
    );

    sipf_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_empty   (q_empty),
        .q_head    (q_head),
        .q_pop     (q_pop),
        .pkt_valid (pkt_valid),
        .pkt_stall (pkt_stall),
        .pkt       (pkt)
    );

endmodule

### sim/tb_servo_instruction_packet_framer_unit.sv
// Self-checking testbench for the servo instruction packet framer: directed table, then
// random well-formed, broken and stray request streams, checked byte by byte.
// Depends on sipf_pkg and servo_instruction_packet_framer_unit.
module tb_servo_instruction_packet_framer_unit;
    timeunit 1ns;
    timeprecision 1ps;

    import sipf_pkg::*;

    localparam int unsigned RANDOM_REQUESTS = 425;
    localparam int unsigned QUIET_LIMIT     = 5000;
    localparam int unsigned DRAIN_CYCLES    = 30;
    localparam int unsigned MAX_PRINTED     = 40;

    localparam out_item_t STRAY_BYTE = '{8'h00, 1'b1, 1'b1};
    localparam out_item_t SYNC_BYTE  = '{HDR_SYNC, 1'b0, 1'b0};
    localparam out_item_t NOT_TYPED  = '0;

    typedef struct {
        in_item_t  req;
        bit        typed;
        out_item_t first;
    } table_row_t;

    logic      clk;
    logic      rst_n = 1'b0;
    logic      cmd_valid = 1'b0;
    in_item_t  cmd = '0;
    logic      cmd_stall;
    logic      pkt_valid;
    logic      pkt_stall = 1'b0;
    out_item_t pkt;

    // Framer state as predicted from the accepted requests.
    logic [15:0] run_crc = CRC_INIT;
    logic [7:0]  params_due = '0;
    bit          pkt_open = 1'b0;

    out_item_t   expected_bytes[$];
    table_row_t  directed_rows[$];

    bit          steady = 1'b0;
    int unsigned mismatches = 0;
    int unsigned requests_sent = 0;
    int unsigned bytes_checked = 0;
    int unsigned packets_closed = 0;
    int unsigned strays_seen = 0;
    int unsigned quiet_cycles = 0;

    servo_instruction_packet_framer_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_stall (cmd_stall),
        .pkt_valid (pkt_valid),
        .pkt_stall (pkt_stall),
        .pkt       (pkt)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // CRC-16, polynomial 0x8005, one message bit at a time from the MSB.
    function automatic logic [15:0] crc_next(logic [15:0] crc, logic [7:0] b);
        logic feedback;
        for (int i = 7; i >= 0; i--)
        begin
            feedback = crc[15] ^ b[i];
            crc = {crc[14:0], 1'b0};
            if (feedback)
            begin
                crc = crc ^ CRC_POLY;
            end
        end
        return crc;
    endfunction

    task automatic push_data(logic [7:0] b);
        run_crc = crc_next(run_crc, b);
        expected_bytes.push_back('{b, 1'b0, 1'b0});
    endtask

    task automatic close_packet();
        expected_bytes.push_back('{run_crc[7:0], 1'b0, 1'b0});
        expected_bytes.push_back('{run_crc[15:8], 1'b1, 1'b0});
        pkt_open = 1'b0;
        params_due = '0;
        run_crc = CRC_INIT;
    endtask

    // Works out the bytes one accepted request produces and updates the framer state.
    task automatic frame_request(in_item_t req);
        logic [7:0] count;
        logic [7:0] header[8];
        if (req.op == OP_START)
        begin
            count = (req.param_count > MAX_PARAMS) ? MAX_PARAMS : req.param_count;
            header = '{HDR_SYNC, HDR_SYNC, HDR_MARK, HDR_ZERO, req.target_id,
                       count + LEN_EXTRA, HDR_ZERO, req.instruction};
            run_crc = CRC_INIT;
            foreach (header[k])
            begin
                push_data(header[k]);
            end
            if (count == 0)
            begin
                close_packet();
            end
            else
            begin
                pkt_open = 1'b1;
                params_due = count;
            end
        end
        else if (!pkt_open || params_due == 0)
        begin
            expected_bytes.push_back(STRAY_BYTE);
        end
        else
        begin
            push_data(req.data_byte);
            params_due = params_due - 8'd1;
            if (params_due == 0)
            begin
                close_packet();
            end
        end
    endtask

    task automatic report_mismatch(string what, logic [7:0] got, logic [7:0] want);
        mismatches++;
        if (mismatches <= MAX_PRINTED)
        begin
            $display("[%0t] byte %0d: %s got %02h want %02h", $realtime, bytes_checked,
                     what, got, want);
        end
    endtask

    function automatic in_item_t rand_item(logic op);
        in_item_t it;
        it.op = op;
        it.target_id = 8'($urandom);
        it.instruction = 8'($urandom);
        it.param_count = 8'($urandom);
        it.data_byte = 8'($urandom);
        return it;
    endfunction

    // Presents one request, holds it until it is taken, then records what it must produce.
    // A typed first byte replaces the predicted one so the row checks the block directly.
    task automatic send_request(in_item_t req, bit typed, out_item_t first);
        int n0;
        while (!steady && $urandom_range(0, 99) < 23)
        begin
            cmd_valid <= 1'b0;
            @(posedge clk);
        end
        cmd_valid <= 1'b1;
        cmd <= req;
        @(posedge clk);
        while (cmd_stall)
        begin
            @(posedge clk);
        end
        n0 = expected_bytes.size();
        frame_request(req);
        if (typed)
        begin
            expected_bytes[n0] = first;
        end
        requests_sent++;
    endtask

    task automatic add_row(logic op, logic [7:0] id, logic [7:0] instr, logic [7:0] count,
                           logic [7:0] data, bit typed, out_item_t first);
        table_row_t row;
        row.req = '{op, id, instr, count, data};
        row.typed = typed;
        row.first = first;
        directed_rows.push_back(row);
    endtask

    // Output checker, receiver stall and activity counter for the watchdog.
    always @(posedge clk)
    begin
        if (rst_n && pkt_valid && !pkt_stall)
        begin
            if (expected_bytes.size() == 0)
            begin
                report_mismatch("unexpected byte", pkt.out_byte, 8'h00);
            end
            else
            begin
                if (pkt.out_byte !== expected_bytes[0].out_byte)
                begin
                    report_mismatch("out_byte", pkt.out_byte, expected_bytes[0].out_byte);
                end
                if (pkt.last !== expected_bytes[0].last)
                begin
                    report_mismatch("last", 8'(pkt.last), 8'(expected_bytes[0].last));
                end
                if (pkt.error !== expected_bytes[0].error)
                begin
                    report_mismatch("error", 8'(pkt.error), 8'(expected_bytes[0].error));
                end
                void'(expected_bytes.pop_front());
            end
            bytes_checked++;
            if (pkt.last && pkt.error)
            begin
                strays_seen++;
            end
            else if (pkt.last)
            begin
                packets_closed++;
            end
        end
        if ((cmd_valid && !cmd_stall) || (pkt_valid && !pkt_stall))
        begin
            quiet_cycles <= 0;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
        pkt_stall <= !steady && ($urandom_range(0, 99) < 23);
    end

    initial
    begin
        wait (quiet_cycles >= QUIET_LIMIT);
        $display("Stalled for %0d cycles with %0d bytes outstanding", quiet_cycles,
                 expected_bytes.size());
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial
    begin
        int unsigned random_sent;
        int unsigned roll;
        int unsigned count;
        int unsigned n_params;
        bit          big_done;
        in_item_t    req;

        random_sent = 0;
        big_done = 1'b0;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Stray parameter straight after reset, zero-count starts at both field extremes.
        add_row(OP_PARAM, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b1, STRAY_BYTE);
        add_row(OP_START, 8'h00, 8'h00, 8'h00, 8'h00, 1'b1, SYNC_BYTE);
        add_row(OP_START, 8'hFF, 8'hFF, 8'h00, 8'hFF, 1'b1, SYNC_BYTE);
        // Count above the cap, two bytes, then a restart that drops the open packet.
        add_row(OP_START, 8'hFE, 8'h01, 8'hFF, 8'h00, 1'b1, SYNC_BYTE);
        add_row(OP_PARAM, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0, NOT_TYPED);
        add_row(OP_PARAM, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b0, NOT_TYPED);
        add_row(OP_START, 8'h01, 8'h03, 8'h02, 8'h00, 1'b1, SYNC_BYTE);
        add_row(OP_PARAM, 8'h00, 8'h00, 8'h00, 8'hAA, 1'b0, NOT_TYPED);
        add_row(OP_PARAM, 8'hFF, 8'hFF, 8'hFF, 8'h55, 1'b0, NOT_TYPED);
        add_row(OP_PARAM, 8'h00, 8'h00, 8'h00, 8'h7F, 1'b1, STRAY_BYTE);
        add_row(OP_START, 8'hFE, 8'h08, 8'hFD, 8'hFF, 1'b1, SYNC_BYTE);
        add_row(OP_START, 8'h80, 8'h02, 8'hFC, 8'h00, 1'b1, SYNC_BYTE);
        add_row(OP_PARAM, 8'h00, 8'h00, 8'h00, 8'h80, 1'b0, NOT_TYPED);
        add_row(OP_START, 8'h7F, 8'h83, 8'h01, 8'hFF, 1'b1, SYNC_BYTE);
        add_row(OP_PARAM, 8'hFF, 8'hFF, 8'hFF, 8'h01, 1'b0, NOT_TYPED);
        add_row(OP_START, 8'h00, 8'h55, 8'h03, 8'h00, 1'b1, SYNC_BYTE);
        add_row(OP_PARAM, 8'h00, 8'h00, 8'h00, 8'h12, 1'b0, NOT_TYPED);
        add_row(OP_PARAM, 8'h00, 8'h00, 8'h00, 8'h34, 1'b0, NOT_TYPED);
        add_row(OP_PARAM, 8'h00, 8'h00, 8'h00, 8'h56, 1'b0, NOT_TYPED);
        add_row(OP_PARAM, 8'h00, 8'h00, 8'h00, 8'h00, 1'b1, STRAY_BYTE);
        add_row(OP_START, 8'h0F, 8'hF0, 8'h01, 8'hA5, 1'b1, SYNC_BYTE);
        add_row(OP_PARAM, 8'hF0, 8'h0F, 8'h00, 8'h00, 1'b0, NOT_TYPED);

        foreach (directed_rows[r])
        begin
            send_request(directed_rows[r].req, directed_rows[r].typed, directed_rows[r].first);
        end

        // Mostly complete packets with random content; some cut short or stray.
        while (random_sent < RANDOM_REQUESTS)
        begin
            steady = (random_sent >= 150 && random_sent < 260);
            roll = $urandom_range(0, 99);
            if (!big_done && random_sent >= 100)
            begin
                count = $urandom_range(253, 255);
                n_params = MAX_PARAMS;
                big_done = 1'b1;
            end
            else if (roll < 14 && roll >= 8)
            begin
                count = $urandom_range(1, 6);
                n_params = $urandom_range(0, count - 1);
            end
            else if (roll < 19)
            begin
                count = $urandom_range(9, 40);
                n_params = count;
            end
            else
            begin
                count = $urandom_range(0, 8);
                n_params = count;
            end
            if (roll < 8 && !(random_sent >= 100 && n_params == MAX_PARAMS))
            begin
                send_request(rand_item(OP_PARAM), 1'b0, NOT_TYPED);
                random_sent++;
            end
            else
            begin
                req = rand_item(OP_START);
                req.param_count = 8'(count);
                send_request(req, 1'b0, NOT_TYPED);
                random_sent++;
                repeat (n_params)
                begin
                    send_request(rand_item(OP_PARAM), 1'b0, NOT_TYPED);
                    random_sent++;
                end
            end
        end
        steady = 1'b0;
        cmd_valid <= 1'b0;

        while (expected_bytes.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Sent %0d requests; checked %0d bytes: %0d packets closed with CRC, %0d strays.",
                 requests_sent, bytes_checked, packets_closed, strays_seen);
        $display("Covered capped counts, restarts, zero-count starts and one full-length packet.");
        if (mismatches == 0 && expected_bytes.size() == 0)
        begin
            $display("SCOREBOARD CLEAN");
        end
        else
        begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
